[rtl/ebra_pkg.sv]
// Shared constants and types for the event burst rate alarm.
// No dependencies; every other file uses it by scoped names.
package ebra_pkg;

  localparam int MAX_COUNT  = 64;
  localparam int TIME_BITS  = 48;
  localparam int CNT_W      = 7;
  localparam int WIN_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int CELLS   = MAX_COUNT;
  localparam int SAT_W   = $clog2(MAX_COUNT + 1);
  localparam int N_W     = (CNT_W > SAT_W) ? CNT_W : SAT_W;
  localparam int CMP_W   = (TIME_BITS > WIN_W) ? TIME_BITS : WIN_W;

  localparam logic [CFG_IDX_W-1:0] REG_COUNT_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_WINDOW     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_ENABLE   = 2'd2;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef struct packed {
    logic  alarm;
    time_t oldest_time;
  } result_t;

  typedef struct packed {
    logic clear;
    logic shift;
    logic insert;
  } cell_ctrl_t;

endpackage

[rtl/ebra_if.sv]
// Valid/ready channel interfaces for event beats and result beats.
// Depends on ebra_pkg.
interface ebra_evt_if;
  logic               valid;
  logic               ready;
  ebra_pkg::time_t    event_time;

  modport source (output valid, output event_time, input ready);
  modport sink   (input valid, input event_time, output ready);
endinterface

interface ebra_res_if;
  logic               valid;
  logic               ready;
  logic               alarm;
  ebra_pkg::time_t    oldest_time;

  modport source (output valid, output alarm, output oldest_time, input ready);
  modport sink   (input valid, input alarm, input oldest_time, output ready);
endinterface

[rtl/ebra_cell.sv]
// One timestamp cell of the history chain; loads the new event or its neighbor.
// Depends on ebra_pkg.
module ebra_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  ebra_pkg::cell_ctrl_t ctrl,
  input  ebra_pkg::time_t      now,
  input  ebra_pkg::time_t      from_next,
  output ebra_pkg::time_t      q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (ctrl.clear) begin
      q <= '0;
    end else if (ctrl.shift) begin
      q <= ctrl.insert ? now : from_next;
    end
  end

endmodule

[rtl/ebra_out_buf.sv]
// Two-entry output buffer (output register plus skid) for result beats.
// Depends on ebra_pkg and ebra_res_if.
module ebra_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ebra_pkg::result_t push_data,
  output logic              can_push,
  ebra_res_if.source        res
);

  logic              out_valid;
  ebra_pkg::result_t out_data;
  logic              skid_valid;
  ebra_pkg::result_t skid_data;

  assign can_push        = !skid_valid;
  assign res.valid       = out_valid;
  assign res.alarm       = out_data.alarm;
  assign res.oldest_time = out_data.oldest_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || res.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || res.ready) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

[rtl/event_burst_rate_alarm.sv]
// Top level of the event burst rate alarm: config registers, cell chain, compare.
// Depends on ebra_pkg, ebra_if, ebra_cell and ebra_out_buf.
//
// Takes one event beat per clock while the output buffer can accept a result, and
// returns exactly one result beat per event, registered through a two-entry
// output buffer, so one more event is taken while a result waits. The
// recent-event history is a chain of MAX_COUNT cells: each enabled event is
// written into the cell at position N-2 (N = count threshold, capped at
// MAX_COUNT) while the other cells shift down one place, so cell 0 holds the
// oldest of the N-1 most recent events. The loops between events are the
// last-alarm-time register and the cell chain, both updated when the event is
// accepted; with these the rate is one event per cycle unless the buffer stalls.
// Writing count_threshold clears the whole chain. Events are ignored (alarm 0,
// oldest_time 0, no state change) while the threshold is zero or reporting is off.
module event_burst_rate_alarm (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ebra_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ebra_pkg::CFG_DATA_W-1:0]     cfg_data,
  ebra_evt_if.sink                            evt,
  ebra_res_if.source                          res
);

  logic [ebra_pkg::CNT_W-1:0] count_threshold;
  logic [ebra_pkg::WIN_W-1:0] time_window;
  logic                       report_enable;
  ebra_pkg::time_t            last_alarm_time;

  logic [ebra_pkg::N_W-1:0]   n_eff;
  logic [ebra_pkg::N_W-1:0]   thr_ext;
  logic                       en;
  logic                       accept;
  logic                       can_push;
  logic                       clear_chain;
  logic                       alarm_now;
  ebra_pkg::time_t            now;
  ebra_pkg::time_t            oldest;
  ebra_pkg::time_t            since_alarm;
  ebra_pkg::time_t            span;
  logic [ebra_pkg::CMP_W-1:0] half_window;
  logic [ebra_pkg::CMP_W-1:0] full_window;
  ebra_pkg::result_t          result;

  ebra_pkg::time_t            cell_q   [ebra_pkg::CELLS];
  ebra_pkg::time_t            cell_nbr [ebra_pkg::CELLS];

  assign now         = evt.event_time;
  assign evt.ready   = can_push;
  assign accept      = evt.valid && can_push;
  assign clear_chain = cfg_we && (cfg_index == ebra_pkg::REG_COUNT_THRESHOLD);

  assign thr_ext = ebra_pkg::N_W'(count_threshold);
  assign n_eff   = (thr_ext > ebra_pkg::N_W'(ebra_pkg::MAX_COUNT)) ?
                   ebra_pkg::N_W'(ebra_pkg::MAX_COUNT) : thr_ext;
  assign en      = (n_eff != '0) && report_enable;

  // single-entry window: the oldest event is the current one
  assign oldest = (n_eff == ebra_pkg::N_W'(1)) ? now : cell_q[0];

  assign since_alarm = now - last_alarm_time;
  assign span        = now - oldest;
  assign half_window = ebra_pkg::CMP_W'(time_window >> 1);
  assign full_window = ebra_pkg::CMP_W'(time_window);

  assign alarm_now = en &&
                     (ebra_pkg::CMP_W'(since_alarm) > half_window) &&
                     (ebra_pkg::CMP_W'(span) <= full_window);

  assign result.alarm       = alarm_now;
  assign result.oldest_time = alarm_now ? oldest : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_threshold <= '0;
      time_window     <= '0;
      report_enable   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        ebra_pkg::REG_COUNT_THRESHOLD: count_threshold <= cfg_data[ebra_pkg::CNT_W-1:0];
        ebra_pkg::REG_TIME_WINDOW:     time_window     <= cfg_data[ebra_pkg::WIN_W-1:0];
        ebra_pkg::REG_REPORT_ENABLE:   report_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_alarm_time <= '0;
    end else if (accept && alarm_now) begin
      last_alarm_time <= now;
    end
  end

  for (genvar i = 0; i < ebra_pkg::CELLS; i++) begin : g_cell
    ebra_pkg::cell_ctrl_t ctrl;

    if (i == ebra_pkg::CELLS - 1) begin : g_last
      assign cell_nbr[i] = '0;
    end else begin : g_mid
      assign cell_nbr[i] = cell_q[i+1];
    end

    assign ctrl.clear  = clear_chain;
    assign ctrl.shift  = accept && en;
    assign ctrl.insert = (n_eff == ebra_pkg::N_W'(i + 2));

    ebra_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .now       (now),
      .from_next (cell_nbr[i]),
      .q         (cell_q[i])
    );
  end

  ebra_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .can_push  (can_push),
    .res       (res)
  );

`ifndef SYNTHESIS
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    !evt.ready |-> res.valid)
    else $error("input stalled with no result pending");

  a_alarm_records_time: assert property (@(posedge clk) disable iff (rst)
    (accept && alarm_now) |=> (last_alarm_time == $past(now)))
    else $error("alarm did not record its time");

  a_idle_keeps_alarm_time: assert property (@(posedge clk) disable iff (rst)
    (accept && !en) |=> $stable(last_alarm_time))
    else $error("disabled beat changed last alarm time");

  a_threshold_write_clears: assert property (@(posedge clk) disable iff (rst)
    clear_chain |=> (cell_q[0] == '0))
    else $error("threshold write left history in the chain");
`endif

endmodule
